@@ src/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler core
// Holds the operand widths, the pole codes, the CORDIC arctangent table and
// the rounding from Q.28 radians to Q4.12.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int unsigned OPW        = 34;  // CORDIC operand width
  localparam int unsigned ANGW       = 32;  // angle accumulator width, Q.28
  localparam int unsigned ISQ_STAGES = 29;  // one result bit per square root stage
  localparam int unsigned ATAN_LEN   = 24;

  localparam logic signed [ANGW-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [15:0]     HALF_PI_Q12 = 16'sd6434;

  typedef enum logic [1:0] {
    PC_REGULAR = 2'd0,
    PC_NORTH   = 2'd1,
    PC_SOUTH   = 2'd2
  } pole_e;

  // Work carried alongside the square root pipeline.
  typedef struct packed {
    logic signed [29:0]    s;
    logic signed [OPW-1:0] y_num;
    logic signed [OPW-1:0] y_den;
    logic signed [OPW-1:0] z_num;
    logic signed [OPW-1:0] z_den;
    pole_e                 pole;
  } dly_t;

  function automatic logic signed [ANGW-1:0] atan_q28(input logic [4:0] idx);
    logic signed [ANGW-1:0] r;
    case (idx)
      5'd0:    r = 32'sd210828714;
      5'd1:    r = 32'sd124459457;
      5'd2:    r = 32'sd65760959;
      5'd3:    r = 32'sd33381290;
      5'd4:    r = 32'sd16755422;
      5'd5:    r = 32'sd8385879;
      5'd6:    r = 32'sd4193963;
      5'd7:    r = 32'sd2097110;
      5'd8:    r = 32'sd1048571;
      5'd9:    r = 32'sd524287;
      5'd10:   r = 32'sd262144;
      5'd11:   r = 32'sd131072;
      5'd12:   r = 32'sd65536;
      5'd13:   r = 32'sd32768;
      5'd14:   r = 32'sd16384;
      5'd15:   r = 32'sd8192;
      5'd16:   r = 32'sd4096;
      5'd17:   r = 32'sd2048;
      5'd18:   r = 32'sd1024;
      5'd19:   r = 32'sd512;
      5'd20:   r = 32'sd256;
      5'd21:   r = 32'sd128;
      5'd22:   r = 32'sd64;
      5'd23:   r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round to nearest, ties upward, from Q.28 to Q4.12.
  function automatic logic [15:0] round_q12(input logic signed [OPW-1:0] v);
    logic signed [OPW-1:0] t;
    t = v + 34'sd32768;
    return t[31:16];
  endfunction

endpackage

@@ src/qte_isqrt.sv @@
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined exact integer square root
// Restoring square root of a 57-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt
  import qte_pkg::*;
(
  input  logic        clk_i,
  input  logic [56:0] val_i,
  output logic [28:0] root_o
);

  logic [57:0] rem_q [ISQ_STAGES];
  logic [57:0] res_q [ISQ_STAGES];

  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
    localparam logic [57:0] Bit = 58'd1 << (56 - 2 * k);
    logic [57:0] rem_in, res_in, trial, rem_d, res_d;

    always_comb begin
      rem_in = (k == 0) ? {1'b0, val_i} : rem_q[(k == 0) ? 0 : k - 1];
      res_in = (k == 0) ? '0 : res_q[(k == 0) ? 0 : k - 1];
      trial  = res_in + Bit;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + Bit;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      res_q[k] <= res_d;
    end
  end

  assign root_o = res_q[ISQ_STAGES-1][28:0];

endmodule

@@ src/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC arctangent
// Gives atan2(num, den) in Q.28 radians from a registered pipeline: a quadrant
// fold, a leading-one search, a normalising shift, then one rotation a stage.
// ----------------------------------------------------------------------------
module qte_cordic
  import qte_pkg::*;
#(
  parameter int unsigned STEPS = 14
) (
  input  logic                   clk_i,
  input  logic signed [OPW-1:0]  num_i,
  input  logic signed [OPW-1:0]  den_i,
  output logic signed [ANGW-1:0] ang_o
);

  localparam int unsigned NIT = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;

  // Fold stage.
  logic signed [OPW:0]   fa_d, fb_d, fa_q, fb_q, absb;
  logic signed [ANGW-1:0] fang_d, fang_q;
  logic [OPW:0]          fm_d, fm_q;

  always_comb begin
    fa_d   = {den_i[OPW-1], den_i};
    fb_d   = {num_i[OPW-1], num_i};
    fang_d = '0;
    if (den_i[OPW-1]) begin
      fang_d = num_i[OPW-1] ? -PI_Q28 : PI_Q28;
      fa_d   = -fa_d;
      fb_d   = -fb_d;
    end
    absb = fb_d[OPW] ? -fb_d : fb_d;
    fm_d = fa_d | absb;
  end

  always_ff @(posedge clk_i) begin
    fa_q   <= fa_d;
    fb_q   <= fb_d;
    fang_q <= fang_d;
    fm_q   <= fm_d;
  end

  // Leading-one search.
  logic signed [OPW:0]    la_q, lb_q;
  logic signed [ANGW-1:0] lang_q;
  logic [5:0]             lp_d, lp_q;
  logic                   lz_q;

  always_comb begin
    lp_d = '0;
    for (int j = 0; j <= OPW; j++) begin
      if (fm_q[j]) lp_d = 6'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    la_q   <= fa_q;
    lb_q   <= fb_q;
    lang_q <= fang_q;
    lp_q   <= lp_d;
    lz_q   <= (fm_q == '0);
  end

  // Normalise so that the larger magnitude lies in [2^29, 2^30).
  logic signed [OPW-1:0]  ia_q  [NIT+1];
  logic signed [OPW-1:0]  ib_q  [NIT+1];
  logic signed [ANGW-1:0] ang_q [NIT+1];
  logic                   zr_q  [NIT+1];
  logic signed [OPW-1:0]  na_d, nb_d;
  logic signed [63:0]     wa, wb;

  always_comb begin
    wa = 64'(la_q);
    wb = 64'(lb_q);
    if (lp_q >= 6'd30) begin
      wa = wa >>> (lp_q - 6'd29);
      wb = wb >>> (lp_q - 6'd29);
    end else begin
      wa = wa <<< (6'd29 - lp_q);
      wb = wb <<< (6'd29 - lp_q);
    end
    na_d = wa[OPW-1:0];
    nb_d = wb[OPW-1:0];
  end

  always_ff @(posedge clk_i) begin
    ia_q[0]  <= na_d;
    ib_q[0]  <= nb_d;
    ang_q[0] <= lang_q;
    zr_q[0]  <= lz_q;
  end

  for (genvar i = 0; i < NIT; i++) begin : g_iter
    logic signed [OPW-1:0]  a_d, b_d;
    logic signed [ANGW-1:0] g_d;

    always_comb begin
      if (ib_q[i] > 0) begin
        a_d = ia_q[i] + (ib_q[i] >>> i);
        b_d = ib_q[i] - (ia_q[i] >>> i);
        g_d = ang_q[i] + atan_q28(5'(i));
      end else begin
        a_d = ia_q[i] - (ib_q[i] >>> i);
        b_d = ib_q[i] + (ia_q[i] >>> i);
        g_d = ang_q[i] - atan_q28(5'(i));
      end
    end

    always_ff @(posedge clk_i) begin
      ia_q[i+1]  <= a_d;
      ib_q[i+1]  <= b_d;
      ang_q[i+1] <= g_d;
      zr_q[i+1]  <= zr_q[i];
    end
  end

  // Both operands zero gives a zero angle.
  assign ang_o = zr_q[NIT] ? '0 : ang_q[NIT];

endmodule

@@ src/quaternion_to_euler_core.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_core: quaternion to Euler angles with pole detection
// Converts a Q2.14 quaternion into three Q4.12 angles and a pole code.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   command  | start_i, busy_o, quat_{w,x,y,z}_i       | in
//   result   | done_o, angle_{x,y,z}_o, pole_case_o    | out
//
// A new word is taken every cycle; busy_o stays low.
// The pipeline is three arithmetic stages, the 29-stage square root, the CORDIC
// pipeline and the output register.
// Reset clears only the valid bits; the data path is free running.
// The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module quaternion_to_euler_core
  import qte_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               done_o,
  output logic signed [15:0] angle_x_o,
  output logic signed [15:0] angle_y_o,
  output logic signed [15:0] angle_z_o,
  output logic [1:0]         pole_case_o
);

  localparam int unsigned NIT  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int unsigned CLAT = 3 + NIT;
  localparam int unsigned LAT  = 3 + ISQ_STAGES + CLAT + 1;

  localparam logic signed [OPW-1:0] OneQ28 = 34'sd268435456;

  function automatic logic signed [31:0] mul16(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [31:0] ae, be;
    ae = 32'(a);
    be = 32'(b);
    return ae * be;
  endfunction

  assign busy_o = 1'b0;

  // Valid bits.
  logic vld_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stage 1: products, exact in Q4.28.
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xw_q, yz_q, wy_q, zx_q, wz_q, xy_q;
  logic signed [15:0] x1_q, y1_q, x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    ww_q <= mul16(quat_w_i, quat_w_i);
    xx_q <= mul16(quat_x_i, quat_x_i);
    yy_q <= mul16(quat_y_i, quat_y_i);
    zz_q <= mul16(quat_z_i, quat_z_i);
    xw_q <= mul16(quat_x_i, quat_w_i);
    yz_q <= mul16(quat_y_i, quat_z_i);
    wy_q <= mul16(quat_w_i, quat_y_i);
    zx_q <= mul16(quat_z_i, quat_x_i);
    wz_q <= mul16(quat_w_i, quat_z_i);
    xy_q <= mul16(quat_x_i, quat_y_i);
    x1_q <= quat_x_i;
    y1_q <= quat_y_i;
  end

  // Stage 2: norm, test value and atan2 operands.
  logic signed [32:0]    test_d, test_q;
  logic signed [33:0]    unit_d, unit_q, twot;
  logic signed [OPW-1:0] yn_d, yd_d, zn_d, zd_d, yn_q, yd_q, zn_q, zd_q;
  logic signed [29:0]    s_d, s_q;

  always_comb begin
    test_d = 33'(xw_q) - 33'(yz_q);
    unit_d = 34'(ww_q) + 34'(xx_q) + 34'(yy_q) + 34'(zz_q);
    yn_d   = (34'(wy_q) + 34'(zx_q)) <<< 1;
    yd_d   = OneQ28 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
    zn_d   = (34'(wz_q) + 34'(xy_q)) <<< 1;
    zd_d   = OneQ28 - ((34'(zz_q) + 34'(xx_q)) <<< 1);
    twot   = 34'(test_d) <<< 1;
    if (twot > OneQ28) begin
      s_d = 30'sd268435456;
    end else if (twot < -OneQ28) begin
      s_d = -30'sd268435456;
    end else begin
      s_d = twot[29:0];
    end
  end

  always_ff @(posedge clk_i) begin
    test_q <= test_d;
    unit_q <= unit_d;
    yn_q   <= yn_d;
    yd_q   <= yd_d;
    zn_q   <= zn_d;
    zd_q   <= zd_d;
    s_q    <= s_d;
    x2_q   <= x1_q;
    y2_q   <= y1_q;
  end

  // Stage 3: pole test and the square root argument 1 - s^2.
  logic signed [45:0] t2000, n999;
  logic signed [59:0] ssq;
  logic [56:0]        rad_d, rad_q;
  dly_t               s3_d;
  dly_t               dly_q [ISQ_STAGES+1];

  always_comb begin
    t2000 = 46'(test_q) * 46'sd2000;
    n999  = 46'(unit_q) * 46'sd999;
    ssq   = 60'(s_q) * 60'(s_q);
    rad_d = 57'(60'sd72057594037927936 - ssq);
    s3_d.s     = s_q;
    s3_d.z_num = zn_q;
    s3_d.z_den = zd_q;
    if (t2000 > n999) begin
      s3_d.pole  = PC_NORTH;
      s3_d.y_num = 34'(y2_q);
      s3_d.y_den = 34'(x2_q);
    end else if (t2000 < -n999) begin
      s3_d.pole  = PC_SOUTH;
      s3_d.y_num = 34'(y2_q);
      s3_d.y_den = 34'(x2_q);
    end else begin
      s3_d.pole  = PC_REGULAR;
      s3_d.y_num = yn_q;
      s3_d.y_den = yd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q    <= rad_d;
    dly_q[0] <= s3_d;
    for (int k = 1; k <= ISQ_STAGES; k++) dly_q[k] <= dly_q[k-1];
  end

  logic [28:0] root;

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .val_i  (rad_q),
    .root_o (root)
  );

  // Three angle units in parallel.
  dly_t                   cd;
  logic signed [ANGW-1:0] ang_x, ang_y, ang_z;

  assign cd = dly_q[ISQ_STAGES];

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_x (
    .clk_i (clk_i),
    .num_i (34'(cd.s)),
    .den_i ({5'd0, root}),
    .ang_o (ang_x)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_y (
    .clk_i (clk_i),
    .num_i (cd.y_num),
    .den_i (cd.y_den),
    .ang_o (ang_y)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_z (
    .clk_i (clk_i),
    .num_i (cd.z_num),
    .den_i (cd.z_den),
    .ang_o (ang_z)
  );

  pole_e pd_q [CLAT];

  always_ff @(posedge clk_i) begin
    pd_q[0] <= cd.pole;
    for (int k = 1; k < CLAT; k++) pd_q[k] <= pd_q[k-1];
  end

  // Output stage.
  logic signed [15:0]    ax_d, ay_d, az_d, ax_q, ay_q, az_q;
  logic signed [OPW-1:0] ay2;
  pole_e                 pc_q;

  always_comb begin
    ay2 = 34'(ang_y) <<< 1;
    case (pd_q[CLAT-1])
      PC_NORTH: begin
        ax_d = HALF_PI_Q12;
        ay_d = $signed(round_q12(ay2));
        az_d = '0;
      end
      PC_SOUTH: begin
        ax_d = -HALF_PI_Q12;
        ay_d = $signed(round_q12(-ay2));
        az_d = '0;
      end
      default: begin
        ax_d = $signed(round_q12(34'(ang_x)));
        ay_d = $signed(round_q12(34'(ang_y)));
        az_d = $signed(round_q12(34'(ang_z)));
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    ay_q <= ay_d;
    az_q <= az_d;
    pc_q <= pd_q[CLAT-1];
  end

  assign done_o      = vld_q[LAT-1];
  assign angle_x_o   = ax_q;
  assign angle_y_o   = ay_q;
  assign angle_z_o   = az_q;
  assign pole_case_o = pc_q;

  // A delivered word never carries the unused pole code.
  a_pole_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pole_case_o == PC_REGULAR || pole_case_o == PC_NORTH ||
                pole_case_o == PC_SOUTH))
    else $error("pole code out of range");

  // At the north pole the pitch is pinned and the roll is zero.
  a_north: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pole_case_o == PC_NORTH) |->
      (angle_x_o == HALF_PI_Q12 && angle_z_o == 16'sd0))
    else $error("north pole word malformed");

  // The south pole is the mirror.
  a_south: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pole_case_o == PC_SOUTH) |->
      (angle_x_o == -HALF_PI_Q12 && angle_z_o == 16'sd0))
    else $error("south pole word malformed");

endmodule

@@ tb/tb_quaternion_to_euler_core.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_core: self-checking bench for the quaternion core
// Drives quaternions through the command port and compares every angle word
// and pole code with a bit-exact fixed-point model kept in this bench.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_core;
  import qte_pkg::*;

  localparam int unsigned STEPS   = 14;
  localparam int unsigned LATENCY = 3 + 29 + 3 + STEPS + 1;
  localparam longint PI_28        = 64'sd843314857;
  localparam longint HALF_PI_12   = 64'sd6434;
  localparam longint ONE_28       = 64'sd1 << 28;

  localparam longint ARCTAN_28 [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097110, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    pole_e              pole;
  } euler_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic               done_o;
  logic signed [15:0] angle_x_o;
  logic signed [15:0] angle_y_o;
  logic signed [15:0] angle_z_o;
  logic [1:0]         pole_case_o;

  euler_t pending_angles[$];
  int     mismatch_count = 0;
  int     idle_pct = 0;

  always #6 clk_i = ~clk_i;

  quaternion_to_euler_core #(.CORDIC_STEPS(STEPS)) DUT (.*);

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring arctangent of num/den in Q.28 radians.
  function automatic longint arctan2_q28(longint num, longint den);
    longint a, b, ang, m, na, nb;
    a = den;
    b = num;
    ang = 0;
    if (a == 0 && b == 0) return 0;
    if (a < 0) begin
      ang = (b >= 0) ? PI_28 : -PI_28;
      a = -a;
      b = -b;
    end
    m = (a < 0 ? -a : a) > (b < 0 ? -b : b) ? (a < 0 ? -a : a) : (b < 0 ? -b : b);
    while (m >= (64'sd1 << 30)) begin
      a = a >>> 1;
      b = b >>> 1;
      m = m >>> 1;
    end
    while (m < (64'sd1 << 29)) begin
      a *= 2;
      b *= 2;
      m *= 2;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (b > 0) begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        ang += ARCTAN_28[i];
      end else begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        ang -= ARCTAN_28[i];
      end
      a = na;
      b = nb;
    end
    return ang;
  endfunction

  function automatic logic [15:0] to_q12(longint v);
    longint r;
    r = (v + (64'sd1 << 15)) >>> 16;
    return r[15:0];
  endfunction

  function automatic euler_t quat_to_euler(logic signed [15:0] qw, logic signed [15:0] qx,
                                           logic signed [15:0] qy, logic signed [15:0] qz);
    euler_t e;
    longint w, x, y, z, norm, tst, s;
    longint unsigned c;
    w = longint'(qw); x = longint'(qx); y = longint'(qy); z = longint'(qz);
    norm = w * w + x * x + y * y + z * z;
    tst = x * w - y * z;
    if (2000 * tst > 999 * norm) begin
      e.ax = HALF_PI_12[15:0];
      e.ay = to_q12(2 * arctan2_q28(y, x));
      e.az = '0;
      e.pole = PC_NORTH;
    end else if (2000 * tst < -999 * norm) begin
      e.ax = -HALF_PI_12[15:0];
      e.ay = to_q12(-2 * arctan2_q28(y, x));
      e.az = '0;
      e.pole = PC_SOUTH;
    end else begin
      s = 2 * tst;
      if (s > ONE_28) s = ONE_28;
      if (s < -ONE_28) s = -ONE_28;
      c = int_sqrt((64'd1 << 56) - longint'(s * s));
      e.ax = to_q12(arctan2_q28(s, longint'(c)));
      e.ay = to_q12(arctan2_q28(2 * (w * y + z * x), ONE_28 - 2 * (x * x + y * y)));
      e.az = to_q12(arctan2_q28(2 * (w * z + x * y), ONE_28 - 2 * (z * z + x * x)));
      e.pole = PC_REGULAR;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Sends one word, idling beforehand with the current probability.
  task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic signed [15:0] qz);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i  <= 1'b1;
    quat_w_i <= qw;
    quat_x_i <= qx;
    quat_y_i <= qy;
    quat_z_i <= qz;
    do @(posedge clk_i); while (busy_o);
    pending_angles.push_back(quat_to_euler(qw, qx, qy, qz));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Mostly unit quaternions, some near the poles, some raw codes.
  task automatic send_random_quat();
    real  c[4], n;
    int   kind;
    logic signed [15:0] q[4];
    kind = $urandom_range(9);
    if (kind < 2) begin
      foreach (q[i]) q[i] = 16'($urandom());
    end else begin
      foreach (c[i]) c[i] = real'($urandom_range(20000)) - 10000.0;
      if (kind < 4) begin
        c[0] = 10000.0;
        c[1] = (kind == 2) ? 10000.0 : -10000.0;
        c[2] = c[2] / 300.0;
        c[3] = c[3] / 300.0;
      end
      n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
      if (n == 0.0) n = 1.0;
      foreach (q[i]) q[i] = 16'($rtoi(c[i] / n * 16384.0));
    end
    send_quat(q[0], q[1], q[2], q[3]);
  endtask

  task automatic test_directed();
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(11585, 11585, 0, 0);       // north pole
    send_quat(11585, -11585, 0, 0);      // south pole
    send_quat(11585, 11585, 0, 1);
    send_quat(0, 0, 11585, -11585);      // north pole through the y*z term
    send_quat(0, -11585, 0, 0);          // negative x on its own
    send_quat(30000, 30000, 30000, 0);   // asin argument saturates high
    send_quat(30000, -30000, 30000, 0);  // and low
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(0, 0, -32768, 0);          // negative denominator, zero numerator
    send_quat(1, -1, 1, -1);
    send_quat(8192, 8192, 8192, 8192);
    stop_sending();
  endtask

  task automatic test_random_light_idle();
    idle_pct = 6;
    repeat (180) send_random_quat();
    stop_sending();
  endtask

  task automatic test_random_heavy_idle();
    idle_pct = 79;
    repeat (130) send_random_quat();
    stop_sending();
  endtask

  task automatic test_random_back_to_back();
    idle_pct = 0;
    repeat (200) send_random_quat();
    stop_sending();
  endtask

  // The sender holds off until the pipeline has emptied, then resumes.
  task automatic test_pause_until_empty();
    idle_pct = 0;
    repeat (10) send_random_quat();
    stop_sending();
    wait_drained();
    repeat (10) send_random_quat();
    stop_sending();
  endtask

  always @(posedge clk_i) begin
    euler_t e;
    if (rst_ni && done_o) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        e = pending_angles.pop_front();
        if (angle_x_o !== e.ax) report_mismatch("angle_x", int'(angle_x_o), int'(e.ax));
        if (angle_y_o !== e.ay) report_mismatch("angle_y", int'(angle_y_o), int'(e.ay));
        if (angle_z_o !== e.az) report_mismatch("angle_z", int'(angle_z_o), int'(e.az));
        if (pole_case_o !== e.pole) begin
          report_mismatch("pole_case", int'(pole_case_o), int'(e.pole));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_light_idle();
    test_random_heavy_idle();
    test_pause_until_empty();
    test_random_back_to_back();
    wait_drained();
    if (pending_angles.size() == 0 && mismatch_count == 0) begin
      $display("** quaternion_to_euler_core: PASSED **");
    end else begin
      $display("** quaternion_to_euler_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("** quaternion_to_euler_core: FAILED **");
    $finish;
  end

endmodule
